[rtl/core/mhnt_pkg.sv]
// Package for the held-note table: outcome codes, register indexes, table
// entry type, divider control struct and fixed field widths. No dependencies.
package mhnt_pkg;

    localparam int STATUS_W = 8;
    localparam int KEY_W    = 7;
    localparam int VEL_W    = 7;
    localparam int OUTC_W   = 3;
    localparam int HCNT_W   = 5;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [OUTC_W-1:0] {
        OUT_IGNORED   = 3'd0,
        OUT_ADDED     = 3'd1,
        OUT_DUPLICATE = 3'd2,
        OUT_FULL      = 3'd3,
        OUT_REMOVED   = 3'd4,
        OUT_NOT_FOUND = 3'd5
    } outcome_t;

    localparam logic [CFG_IDX_W-1:0] REG_NOTE_ON  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VEL_W-1:0] vel;
    } entry_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

[rtl/core/midi_held_note_table.sv]
// Top level of the MIDI held-note table: ordered key/velocity memory,
// sequencer and output register. Depends on mhnt_pkg and mhnt_divider.
//
// One MIDI message per transfer; one result per message. The block takes a
// message only when its sequencer is idle. A message walks the table through
// the table memory, reading and then comparing each entry visited; a
// note-off that hits then moves each later entry down, a read and then a
// write per entry; the mean velocity comes from a running sum through a
// serial divider at one quotient bit per cycle (11 sum bits for 16 entries).
// The result sits in an output register, so the next message can be taken
// while it waits. The table needs no clearing after reset.
module midi_held_note_table #(
    parameter int MAX_HELD_NOTES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // status_byte, key_number, key_velocity
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // outcome, held_count, average_velocity
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mhnt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data
);
    import mhnt_pkg::*;

    localparam int CW = $clog2(MAX_HELD_NOTES + 1);
    localparam int AW = (MAX_HELD_NOTES > 1) ? $clog2(MAX_HELD_NOTES) : 1;
    localparam int SW = $clog2(127 * MAX_HELD_NOTES + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_HELD_NOTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DIV,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [7:0]          on_status_reg;
    logic [7:0]          off_status_reg;
    logic                op_on_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VEL_W-1:0]    vel_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       idx_reg;
    logic [SW-1:0]       sum_reg;
    outcome_t            outcome_reg;
    logic                m_tvalid_reg;
    outcome_t            out_outcome_reg;
    logic [HCNT_W-1:0]   out_count_reg;
    logic [VEL_W-1:0]    out_avg_reg;

    entry_t              mem [MAX_HELD_NOTES];
    entry_t              rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    entry_t              mem_wdata;

    logic [CW-1:0]       idx_plus1;
    logic [7:0]          in_status;
    logic [KEY_W-1:0]    in_key;
    logic [VEL_W-1:0]    in_vel;
    logic                in_xfer;
    logic                out_free;
    logic [CW+HCNT_W-1:0] count_ext;
    div_ctl_t            div_ctl;
    logic [SW-1:0]       div_quo;

    assign in_status = s_tdata[7:0];
    assign in_key    = s_tdata[14:8];
    assign in_vel    = s_tdata[21:15];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_plus1 = idx_reg + 1'b1;
    assign count_ext = {{HCNT_W{1'b0}}, count_reg};
    assign cfg_ready = 1'b1;

    assign div_ctl.start = (state_reg == ST_DIV);

    mhnt_divider #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_ctl.done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_status_reg  <= 8'd144;
            off_status_reg <= 8'd128;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NOTE_ON:  on_status_reg  <= cfg_data;
                REG_NOTE_OFF: off_status_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_raddr = idx_reg[AW-1:0];
        mem_wdata = rd_data_reg;
        unique case (state_reg)
            ST_SEARCH:
            begin
                if (idx_reg != count_reg)
                begin
                    mem_re = 1'b1;
                end
                else if (op_on_reg && (count_reg < MAX_C))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{key: key_reg, vel: vel_reg};
                end
            end
            ST_SHIFT_RD:
            begin
                if (idx_plus1 != count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_plus1[AW-1:0];
                end
            end
            ST_SHIFT_WR:
            begin
                mem_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            sum_reg         <= '0;
            idx_reg         <= '0;
            op_on_reg       <= 1'b0;
            outcome_reg     <= OUT_IGNORED;
            m_tvalid_reg    <= 1'b0;
            out_outcome_reg <= OUT_IGNORED;
            out_count_reg   <= '0;
            out_avg_reg     <= '0;
            key_reg         <= '0;
            vel_reg         <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        key_reg   <= in_key;
                        vel_reg   <= in_vel;
                        idx_reg   <= '0;
                        op_on_reg <= (in_status == on_status_reg);
                        if ((in_status == on_status_reg) || (in_status == off_status_reg))
                        begin
                            state_reg <= ST_SEARCH;
                        end
                        else
                        begin
                            outcome_reg <= OUT_IGNORED;
                            state_reg   <= ST_DIV;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (idx_reg != count_reg)
                    begin
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                        if (!op_on_reg)
                        begin
                            outcome_reg <= OUT_NOT_FOUND;
                        end
                        else if (count_reg < MAX_C)
                        begin
                            outcome_reg <= OUT_ADDED;
                            count_reg   <= count_reg + 1'b1;
                            sum_reg     <= sum_reg + SW'(vel_reg);
                        end
                        else
                        begin
                            outcome_reg <= OUT_FULL;
                        end
                    end
                end
                ST_CMP:
                begin
                    if (rd_data_reg.key == key_reg)
                    begin
                        if (op_on_reg)
                        begin
                            outcome_reg <= OUT_DUPLICATE;
                            state_reg   <= ST_DIV;
                        end
                        else
                        begin
                            sum_reg   <= sum_reg - SW'(rd_data_reg.vel);
                            state_reg <= ST_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_plus1;
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SHIFT_RD:
                begin
                    if (idx_plus1 == count_reg)
                    begin
                        count_reg   <= count_reg - 1'b1;
                        outcome_reg <= OUT_REMOVED;
                        state_reg   <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_SHIFT_WR;
                    end
                end
                ST_SHIFT_WR:
                begin
                    idx_reg   <= idx_plus1;
                    state_reg <= ST_SHIFT_RD;
                end
                ST_DIV:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_ctl.done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg    <= 1'b1;
                        out_outcome_reg <= outcome_reg;
                        out_count_reg   <= count_ext[HCNT_W-1:0];
                        out_avg_reg     <= (count_reg == '0) ? '0 : div_quo[VEL_W-1:0];
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_avg_reg, out_count_reg, out_outcome_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("held count above table depth");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("velocity sum nonzero with empty table");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("ready while a message is in progress");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result not presented after sequencer finished");

endmodule

[rtl/core/mhnt_divider.sv]
// Restoring serial divider for the held-note table, one quotient bit per cycle.
// Imports mhnt_pkg, though it uses no item from the package.
module mhnt_divider #(
    parameter int DW = 11,
    parameter int VW = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [VW-1:0]        divisor,
    output logic                 done,
    output logic [DW-1:0]        quotient
);
    import mhnt_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dvs_reg;
    logic [VW:0]      trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
